[rtl/iphp_pkg.sv]
// Shared types and constants for the IPv4 host:port text parser.
// No dependencies; used by every module of the block except iphp_queue.
`timescale 1ns / 1ps
`default_nettype none

package iphp_pkg;

    // Depth of the queue between the classifier and the parser.
    localparam int QUEUE_DEPTH = 2;

    // Character classes as seen by the parser.
    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_DOT   = 2'd1,
        KIND_COLON = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_char_item;

    localparam int ITEM_W = $bits(t_char_item);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
        logic [15:0] port_number;
    } t_result;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SEP    = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
    localparam logic [2:0] ST_EMPTY_PRT = 3'd3;
    localparam logic [2:0] ST_NON_NUM   = 3'd4;
    localparam logic [2:0] ST_TOO_BIG   = 3'd5;

    // ASCII codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [8:0] OCTET_LIMIT = 9'd256;
    localparam logic [2:0] DOTS_NEEDED = 3'd3;
    localparam logic [2:0] DOT_SAT     = 3'd7;
    localparam logic [1:0] DIGIT_SAT   = 2'd3;

    localparam int OUT_TDATA_W = 56;

endpackage

`default_nettype wire

[rtl/iphp_queue.sv]
// Small first-in first-out queue between the classifier and the parser.
// Generic in width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module iphp_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/iphp_front.sv]
// Input side of the parser: takes characters and sorts them into classes.
// Depends on iphp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iphp_front (
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,
    input  wire logic               i_s_tlast,
    input  wire logic               i_full,
    output logic                    o_push,
    output iphp_pkg::t_char_item    o_item
);

    logic is_digit;
    logic [7:0] offset;

    assign is_digit = (i_s_tdata >= iphp_pkg::CH_ZERO) && (i_s_tdata <= iphp_pkg::CH_NINE);
    assign offset   = i_s_tdata - iphp_pkg::CH_ZERO;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    always_comb begin
        o_item.last  = i_s_tlast;
        o_item.digit = is_digit ? offset[3:0] : 4'd0;
        if (is_digit) begin
            o_item.kind = iphp_pkg::KIND_DIGIT;
        end else if (i_s_tdata == iphp_pkg::CH_DOT) begin
            o_item.kind = iphp_pkg::KIND_DOT;
        end else if (i_s_tdata == iphp_pkg::CH_COLON) begin
            o_item.kind = iphp_pkg::KIND_COLON;
        end else begin
            o_item.kind = iphp_pkg::KIND_OTHER;
        end
    end

endmodule

`default_nettype wire

[rtl/iphp_back.sv]
// Parser core: applies classified characters to the host and port state and
// holds the finished result in an output register. Depends on iphp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iphp_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire logic [iphp_pkg::ITEM_W-1:0] i_q_item,
    output logic                             o_pop,
    input  wire logic                        i_m_tready,
    output logic                             o_m_tvalid,
    output iphp_pkg::t_result                o_result
);

    iphp_pkg::t_char_item item;

    logic [8:0]  r_oct_value,  n_oct_value;
    logic [1:0]  r_oct_digits, n_oct_digits;
    logic [2:0]  r_dot_count,  n_dot_count;
    logic [31:0] r_addr_shift, n_addr_shift;
    logic        r_host_bad,   n_host_bad;
    logic        r_colon_seen, n_colon_seen;
    logic [32:0] r_port_accum, n_port_accum;
    logic        r_port_digit, n_port_digit;
    logic        r_port_bad,   n_port_bad;
    logic        r_out_valid,  n_out_valid;
    iphp_pkg::t_result r_result, n_result;

    logic [11:0] oct_ext, oct_calc;
    logic [35:0] port_ext, port_calc;
    logic [2:0]  dot_inc;
    logic        fire_last;

    assign item      = iphp_pkg::t_char_item'(i_q_item);
    assign o_pop     = i_q_valid && (!item.last || !r_out_valid || i_m_tready);
    assign fire_last = o_pop && item.last;

    // Multiply by ten as two shifted adds.
    assign oct_ext   = {3'b000, r_oct_value};
    assign oct_calc  = (oct_ext << 3) + (oct_ext << 1) + {8'd0, item.digit};
    assign port_ext  = {3'b000, r_port_accum};
    assign port_calc = (port_ext << 3) + (port_ext << 1) + {32'd0, item.digit};
    assign dot_inc   = (r_dot_count < iphp_pkg::DOT_SAT) ? r_dot_count + 1'b1 : r_dot_count;

    always_comb begin
        n_oct_value  = r_oct_value;
        n_oct_digits = r_oct_digits;
        n_dot_count  = r_dot_count;
        n_addr_shift = r_addr_shift;
        n_host_bad   = r_host_bad;
        n_colon_seen = r_colon_seen;
        n_port_accum = r_port_accum;
        n_port_digit = r_port_digit;
        n_port_bad   = r_port_bad;
        n_result     = r_result;

        if (o_pop) begin
            if (item.kind == iphp_pkg::KIND_COLON) begin
                if (r_colon_seen) begin
                    // A later colon folds the earlier one into the host part.
                    n_host_bad = 1'b1;
                end else begin
                    if (r_oct_digits == 2'd0 || r_dot_count != iphp_pkg::DOTS_NEEDED) begin
                        n_host_bad = 1'b1;
                    end
                    n_addr_shift = {r_addr_shift[23:0], r_oct_value[7:0]};
                    n_colon_seen = 1'b1;
                end
                n_port_accum = '0;
                n_port_digit = 1'b0;
                n_port_bad   = 1'b0;
            end else if (r_colon_seen) begin
                if (item.kind == iphp_pkg::KIND_DIGIT) begin
                    if (|port_calc[35:32]) begin
                        n_port_bad   = 1'b1;
                        n_port_accum = {1'b1, 32'd0};
                    end else begin
                        n_port_accum = port_calc[32:0];
                    end
                    n_port_digit = 1'b1;
                end else begin
                    n_port_bad = 1'b1;
                end
            end else begin
                case (item.kind)
                    iphp_pkg::KIND_DIGIT: begin
                        // A zero followed by more digits is a leading zero.
                        if (r_oct_digits == 2'd1 && r_oct_value == 9'd0) begin
                            n_host_bad = 1'b1;
                        end
                        if (oct_calc >= {3'b000, iphp_pkg::OCTET_LIMIT}) begin
                            n_host_bad  = 1'b1;
                            n_oct_value = iphp_pkg::OCTET_LIMIT;
                        end else begin
                            n_oct_value = oct_calc[8:0];
                        end
                        if (r_oct_digits < iphp_pkg::DIGIT_SAT) begin
                            n_oct_digits = r_oct_digits + 1'b1;
                        end
                    end
                    iphp_pkg::KIND_DOT: begin
                        if (r_oct_digits == 2'd0 || dot_inc > iphp_pkg::DOTS_NEEDED) begin
                            n_host_bad = 1'b1;
                        end
                        n_dot_count  = dot_inc;
                        n_addr_shift = {r_addr_shift[23:0], r_oct_value[7:0]};
                        n_oct_value  = '0;
                        n_oct_digits = '0;
                    end
                    default: begin
                        n_host_bad = 1'b1;
                    end
                endcase
            end
        end

        if (fire_last) begin
            n_result.address     = '0;
            n_result.port_number = '0;
            if (!n_colon_seen) begin
                n_result.status = iphp_pkg::ST_NO_SEP;
            end else if (n_host_bad) begin
                n_result.status = iphp_pkg::ST_BAD_ADDR;
            end else begin
                n_result.address = n_addr_shift;
                if (!n_port_digit && !n_port_bad) begin
                    n_result.status = iphp_pkg::ST_EMPTY_PRT;
                end else if (n_port_bad) begin
                    n_result.status = iphp_pkg::ST_NON_NUM;
                end else if (|n_port_accum[32:16]) begin
                    n_result.status = iphp_pkg::ST_TOO_BIG;
                end else begin
                    n_result.status      = iphp_pkg::ST_OK;
                    n_result.port_number = n_port_accum[15:0];
                end
            end
            // Start fresh for the next text.
            n_oct_value  = '0;
            n_oct_digits = '0;
            n_dot_count  = '0;
            n_addr_shift = '0;
            n_host_bad   = 1'b0;
            n_colon_seen = 1'b0;
            n_port_accum = '0;
            n_port_digit = 1'b0;
            n_port_bad   = 1'b0;
        end

        n_out_valid = (r_out_valid && !i_m_tready) || fire_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_value  <= '0;
            r_oct_digits <= '0;
            r_dot_count  <= '0;
            r_addr_shift <= '0;
            r_host_bad   <= 1'b0;
            r_colon_seen <= 1'b0;
            r_port_accum <= '0;
            r_port_digit <= 1'b0;
            r_port_bad   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_oct_value  <= n_oct_value;
            r_oct_digits <= n_oct_digits;
            r_dot_count  <= n_dot_count;
            r_addr_shift <= n_addr_shift;
            r_host_bad   <= n_host_bad;
            r_colon_seen <= n_colon_seen;
            r_port_accum <= n_port_accum;
            r_port_digit <= n_port_digit;
            r_port_bad   <= n_port_bad;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_result;

endmodule

`default_nettype wire

[rtl/ipv4_host_port_string_parser.sv]
// Top level of the IPv4 "a.b.c.d:port" text parser.
// Depends on iphp_pkg, iphp_front, iphp_queue and iphp_back.
//
//  Channel | Dir | Handshake               | Payload
//  --------+-----+-------------------------+-----------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready | tdata = char_code, tlast = last_char
//  m       | out | o_m_tvalid / i_m_tready | tdata = status, address, port_number
//
// One character item is taken per clock cycle while the queue has room; the
// parser core applies each character as it pops it from the queue. The result
// of a text is offered once its final character has passed through the queue
// and the core has registered the result as it consumed that item.
// Reset (i_rst_n low, synchronous) empties the queue and clears all parse state.
// A stalled output only blocks the core when a new result is ready to replace
// the one still held; the queue then fills and o_s_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_host_port_string_parser #(
    parameter int QUEUE_DEPTH = iphp_pkg::QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream.
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,  // [7:0] char_code
    input  wire logic                             i_s_tlast,  // last_char
    // Output stream.
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [2:0] status, [34:3] address, [50:35] port_number, [55:51] zero
    output logic [iphp_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    // Classified characters travel from the front end through the queue.
    iphp_pkg::t_char_item          push_item;
    logic                          push;
    logic                          q_full;
    logic                          q_valid;
    logic [iphp_pkg::ITEM_W-1:0]   q_item;
    logic                          pop;
    iphp_pkg::t_result             result;

    iphp_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (q_full),
        .o_push     (push),
        .o_item     (push_item)
    );

    iphp_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (iphp_pkg::ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    iphp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_result   (result)
    );

    // Fields packed from the lowest bit up, padded to whole bytes.
    assign o_m_tdata = {5'd0, result.port_number, result.address, result.status};

endmodule

`default_nettype wire

[rtl/iphp_checker.sv]
// Port-level checks for the IPv4 host:port parser, bound to the top level.
// Depends on ipv4_host_port_string_parser and iphp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iphp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [iphp_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    // A held result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Status is one of the defined codes.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] <= iphp_pkg::ST_TOO_BIG)
        else $error("undefined status code");

    // The port is only reported on success.
    a_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != iphp_pkg::ST_OK |-> o_m_tdata[50:35] == 16'd0)
        else $error("port reported on a failed parse");

    // No address without a valid host part.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == iphp_pkg::ST_NO_SEP ||
                       o_m_tdata[2:0] == iphp_pkg::ST_BAD_ADDR)
        |-> o_m_tdata[34:3] == 32'd0)
        else $error("address reported for a bad host part");

endmodule

bind ipv4_host_port_string_parser iphp_checker u_checker (.*);

`default_nettype wire

[bench/ipv4_host_port_string_parser_test.sv]
// Self-checking bench for the IPv4 "a.b.c.d:port" text parser.
// Depends on iphp_pkg and ipv4_host_port_string_parser; streams texts in and checks
// each status, address and port result against a cycle-free model of the parse.
`timescale 1ns / 1ps

module ipv4_host_port_string_parser_test;
    import iphp_pkg::*;

    // One parse result, laid out by field rather than by bus position.
    typedef struct {
        logic [2:0]  status;
        logic [31:0] address;
        logic [15:0] port_number;
    } t_endpoint;

    // Scoreboard: follows the parse character by character and keeps the
    // results that the block still owes, oldest first.
    class endpoint_scoreboard;
        logic [8:0]  octet_val;
        logic [1:0]  octet_digs;
        logic [2:0]  dots;
        logic [31:0] addr_acc;
        bit          host_bad;
        bit          colon_seen;
        logic [32:0] port_acc;
        bit          port_digit;
        bit          port_bad;
        t_endpoint   expected_q[$];
        int          errors;
        int          mismatches;

        function new();
            errors     = 0;
            mismatches = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            octet_val  = '0;
            octet_digs = '0;
            dots       = '0;
            addr_acc   = '0;
            host_bad   = 1'b0;
            colon_seen = 1'b0;
            port_acc   = '0;
            port_digit = 1'b0;
            port_bad   = 1'b0;
        endfunction

        function void host_step(logic [7:0] c);
            int unsigned v;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                // A zero followed by another digit is a leading zero.
                if (octet_digs == 2'd1 && octet_val == 9'd0)
                    host_bad = 1'b1;
                v = int'(octet_val) * 10 + int'(c - CH_ZERO);
                if (v >= int'(OCTET_LIMIT)) begin
                    host_bad = 1'b1;
                    v = int'(OCTET_LIMIT);
                end
                octet_val = 9'(v);
                if (octet_digs < DIGIT_SAT)
                    octet_digs++;
            end else if (c == CH_DOT) begin
                if (octet_digs == 2'd0)
                    host_bad = 1'b1;
                if (dots < DOT_SAT)
                    dots++;
                if (dots > DOTS_NEEDED)
                    host_bad = 1'b1;
                addr_acc   = {addr_acc[23:0], octet_val[7:0]};
                octet_val  = '0;
                octet_digs = '0;
            end else begin
                host_bad = 1'b1;
            end
        endfunction

        function void port_step(logic [7:0] c);
            longint unsigned v;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                v = longint'(port_acc) * 10 + longint'(c - CH_ZERO);
                // Anything past 32 bits is clamped and marks the port non-numeric.
                if (v > 64'hFFFF_FFFF) begin
                    port_bad = 1'b1;
                    v = 64'h1_0000_0000;
                end
                port_acc   = 33'(v);
                port_digit = 1'b1;
            end else begin
                port_bad = 1'b1;
            end
        endfunction

        function void note_char(logic [7:0] c, logic is_last);
            t_endpoint res;
            if (c == CH_COLON) begin
                // A later colon pushes the earlier one into the host part.
                if (colon_seen) begin
                    host_bad = 1'b1;
                end else begin
                    if (octet_digs == 2'd0 || dots != DOTS_NEEDED)
                        host_bad = 1'b1;
                    addr_acc   = {addr_acc[23:0], octet_val[7:0]};
                    colon_seen = 1'b1;
                end
                port_acc   = '0;
                port_digit = 1'b0;
                port_bad   = 1'b0;
            end else if (colon_seen) begin
                port_step(c);
            end else begin
                host_step(c);
            end
            if (!is_last)
                return;
            res.address     = '0;
            res.port_number = '0;
            if (!colon_seen) begin
                res.status = ST_NO_SEP;
            end else if (host_bad) begin
                res.status = ST_BAD_ADDR;
            end else begin
                res.address = addr_acc;
                if (!port_digit && !port_bad) begin
                    res.status = ST_EMPTY_PRT;
                end else if (port_bad) begin
                    res.status = ST_NON_NUM;
                end else if (port_acc > 33'hFFFF) begin
                    res.status = ST_TOO_BIG;
                end else begin
                    res.status      = ST_OK;
                    res.port_number = port_acc[15:0];
                end
            end
            expected_q.insert(expected_q.size(), res);
            clear_parse();
        endfunction

        function void flag(string what, longint unsigned want, longint unsigned got);
            errors++;
            if (mismatches < 10)
                $display("%0t mismatch in %s: expected %0h, got %0h", $realtime, what,
                         want, got);
            mismatches++;
        endfunction

        function void check_endpoint(logic [OUT_TDATA_W-1:0] d);
            t_endpoint want;
            if (expected_q.size() == 0) begin
                flag("unexpected result (status shown)", 0, d[2:0]);
                return;
            end
            want = expected_q.pop_front();
            if (d[2:0] !== want.status)
                flag("status", want.status, d[2:0]);
            if (d[34:3] !== want.address)
                flag("address", want.address, d[34:3]);
            if (d[50:35] !== want.port_number)
                flag("port_number", want.port_number, d[50:35]);
            if (d[OUT_TDATA_W-1:51] !== '0)
                flag("padding", 0, d[OUT_TDATA_W-1:51]);
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata  = '0;   // [7:0] char_code
    logic                   i_s_tlast  = 1'b0; // last_char
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [2:0] status, [34:3] address, [50:35] port_number, [55:51] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    endpoint_scoreboard sb;
    logic [7:0]         text_q[$];
    int                 sent_chars    = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    int                 hold_len      = 0;
    int                 hold_seq      = 0;
    int                 hold_seen     = 0;
    int                 hold_left     = 0;

    ipv4_host_port_string_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Result side. A long hold-off requested by the stimulus process is counted
    // down here; otherwise ready drops at random with the current stall rate.
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every result accepted at a rising edge is checked against the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_endpoint(o_m_tdata);
    end

    // Appends one character to the text being built.
    function automatic void add_char(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    // Offers one character, entering and leaving at a falling edge. Idle cycles
    // are inserted before the item at the current idle rate, and valid is only
    // lowered in a step where it is not raised again.
    task automatic send_char(logic [7:0] c, logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_char(c, is_last);
        sent_chars++;
        @(negedge i_clk);
    endtask

    // Sends the built text, flagging its final character.
    task automatic send_text();
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_string(string s);
        text_q.delete();
        foreach (s[i])
            add_char(s[i]);
        send_text();
    endtask

    // Stops offering and returns at a rising edge once no result is owed.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    function automatic void append_decimal(longint unsigned n);
        logic [7:0] digs[$];
        do begin
            digs.push_front(CH_ZERO + 8'(n % 10));
            n = n / 10;
        end while (n != 0);
        foreach (digs[i])
            add_char(digs[i]);
    endfunction

    // Octets lean toward the edges of the legal range, with some too large.
    function automatic int pick_octet();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(999, 256);
            3:       return $urandom_range(9);
            default: return $urandom_range(255);
        endcase
    endfunction

    // Ports cover the 16-bit limit and the 32-bit overflow boundary.
    function automatic longint unsigned pick_port();
        case ($urandom_range(11))
            0:       return 0;
            1:       return 65535;
            2:       return 65536;
            3:       return 64'hFFFF_FFFF;
            4:       return 64'h1_0000_0000;
            5:       return longint'($urandom) * 1000 + $urandom_range(999);
            6:       return $urandom_range(999999);
            default: return $urandom_range(65535);
        endcase
    endfunction

    // Damages a well-formed text in one spot: a stray byte, an extra zero,
    // colon or dot, or a missing character.
    function automatic void mutate_text();
        int pos;
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(4))
            0: text_q[pos] = 8'($urandom_range(255));
            1: text_q.insert(pos, CH_ZERO);
            2: text_q.insert(pos, CH_COLON);
            3: text_q.insert(pos, CH_DOT);
            default: text_q.delete(pos);
        endcase
    endfunction

    // Most texts follow the host:port form with random content so the port checks
    // are reached, some damaged in one spot; the rest have broken hosts or are plain noise.
    function automatic void build_random_text();
        string alphabet;
        int    mix;
        int    n_oct;
        int    n;
        alphabet = "0123456789.:";
        text_q.delete();
        mix = $urandom_range(99);
        if (mix < 60) begin
            for (int k = 0; k < 4; k++) begin
                append_decimal(pick_octet());
                if (k < 3)
                    add_char(CH_DOT);
            end
            add_char(CH_COLON);
            if ($urandom_range(9) != 0)
                append_decimal(pick_port());
            if ($urandom_range(99) < 35)
                mutate_text();
        end else if (mix < 80) begin
            // From none to six octets, some of them empty.
            n_oct = $urandom_range(6);
            for (int k = 0; k < n_oct; k++) begin
                if ($urandom_range(5) != 0)
                    append_decimal(pick_octet());
                if (k < n_oct - 1)
                    add_char(CH_DOT);
            end
            if ($urandom_range(99) < 85) begin
                add_char(CH_COLON);
                append_decimal(pick_port());
            end
        end else begin
            n = $urandom_range(8, 1);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(1) != 0)
                    add_char(alphabet[$urandom_range(11)]);
                else
                    add_char(8'($urandom_range(255)));
            end
        end
        if (text_q.size() == 0)
            add_char(CH_COLON);
    endfunction

    initial begin
        int send_pcts[4];
        int stall_pcts[4];
        int phase_end;

        send_pcts  = '{0, 69, 0, 24};
        stall_pcts = '{0, 0, 69, 24};
        sb = new();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed texts: all-zero address with port zero, a lone colon (the
        // port is empty and the host too), single bytes at both ends of the
        // code range with no separator, doubled colons, and a final colon
        // after a good host.
        send_string("0.0.0.0:0");
        send_string(":");
        text_q = '{8'hFF};
        send_text();
        text_q = '{8'h00};
        send_text();
        send_string("::");
        send_string("1::2");
        send_string("9.9.9.9:");

        for (int phase = 0; phase < 4; phase++) begin
            // The sender pauses here until every result owed has come back.
            wait_drained();
            send_idle_pct = send_pcts[phase];
            stall_pct     = stall_pcts[phase];
            if (phase == 0) begin
                hold_len = 80;
                hold_seq++;
            end
            @(negedge i_clk);
            if (phase == 0) begin
                // Short texts against a long output hold-off, so the result
                // register and the character queue fill and the input stalls.
                for (int k = 0; k < 12; k++) begin
                    text_q.delete();
                    repeat ($urandom_range(3, 1))
                        add_char(8'($urandom_range(255)));
                    send_text();
                end
            end
            phase_end = sent_chars + 470;
            while (sent_chars < phase_end) begin
                build_random_text();
                send_text();
            end
        end

        wait_drained();
        // Keep the clock running so that a spurious trailing result is caught.
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(3_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[ipv4_host_port_string_parser.f]
rtl/iphp_pkg.sv
rtl/iphp_queue.sv
rtl/iphp_front.sv
rtl/iphp_back.sv
rtl/ipv4_host_port_string_parser.sv
rtl/iphp_checker.sv
bench/ipv4_host_port_string_parser_test.sv
